@@ sv/mpla_pkg.sv @@
// Package for the multi-pool layer allocator: sizes, field widths, codes.
// Used by multi_pool_layer_allocator_top and the testbench; depends on nothing.
package mpla_pkg;

    localparam int NUM_POOLS  = 4;
    localparam int MAX_LAYERS = 32;
    localparam int REG_POOLS  = 4;   // pools that have a layer-count register

    // field widths fixed by the interface
    localparam int ACT_W   = 2;
    localparam int POOL_W  = 3;
    localparam int LSEL_W  = 6;
    localparam int STAT_W  = 2;
    localparam int GRANT_W = 5;
    localparam int UCNT_W  = 6;
    localparam int TOT_W   = 3;
    localparam int LRAW_W  = 6;

    // derived sizes
    localparam int PA_W   = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
    localparam int LIDX_W = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
    localparam int CNT_W  = $clog2(MAX_LAYERS + 1);
    localparam int WORD_W = MAX_LAYERS + CNT_W;

    // configuration port
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;
    localparam int NUM_REGS = 5;

    localparam logic [2:0] REG_POOL_TOTAL = 3'd0;
    localparam logic [2:0] REG_LAYERS0    = 3'd1;

    localparam logic [ACT_W-1:0] ACT_ALLOC   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CHECK   = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD_POOL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STAT_W-1:0] ST_BAD_LAYER = 2'd3;

    // layer count clipped to the bitmap size
    function automatic logic [CNT_W-1:0] eff_layers(input logic [LRAW_W-1:0] raw);
        logic [CNT_W-1:0] n;
        if (raw > LRAW_W'(MAX_LAYERS)) begin
            n = CNT_W'(MAX_LAYERS);
        end else begin
            n = CNT_W'(raw);
        end
        return n;
    endfunction

endpackage

@@ sv/mpla_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; no package needed.
module mpla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

@@ sv/multi_pool_layer_allocator_top.sv @@
// Multi-pool layer allocator: first-fit layer allocation over per-pool bitmaps.
// Depends on mpla_pkg and mpla_ram.
//
// Use: request items (action, pool_sel, layer_sel) enter on i_in_valid while
// o_in_stall is low; each gives exactly one result item (status,
// granted_layer, is_live, used_count) on o_out_valid, taken while i_out_stall
// is low. Pools and their layer counts are set over the APB port; writing a
// pool's layer count empties that pool.
// Each pool's bitmap and used count sit in one RAM word. The accept edge issues
// the RAM read; the modify step then modifies the word, writes it back and
// loads the output register. The one RAM port pair and its registered read
// mean no new item is taken before the last one's result is loaded; the next
// item is accepted in the cycle after the result is loaded, so read after
// write to the same pool needs no forwarding.
// If the receiver stalls with a result still pending, the next item waits in
// the modify step (its read data stays valid) until the output frees up.
// Reset (synchronous, active low) clears the state, output-valid and configuration
// registers and marks every pool word invalid, so all bitmaps read as empty; no clearing pass is needed.
module multi_pool_layer_allocator_top
    import mpla_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // request channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [ACT_W-1:0]    i_action,
    input  logic [POOL_W-1:0]   i_pool_sel,
    input  logic [LSEL_W-1:0]   i_layer_sel,
    // result channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [STAT_W-1:0]   o_status,
    output logic [GRANT_W-1:0]  o_granted_layer,
    output logic                o_is_live,
    output logic [UCNT_W-1:0]   o_used_count,
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic                r_state, n_state;
    logic [ACT_W-1:0]    r_act;
    logic [POOL_W-1:0]   r_pool;
    logic [LSEL_W-1:0]   r_layer;
    logic [NUM_POOLS-1:0] r_vld;

    logic [TOT_W-1:0]    r_total;
    logic [LRAW_W-1:0]   r_layers [NUM_POOLS];

    logic                r_out_valid;
    logic [STAT_W-1:0]   r_status;
    logic [GRANT_W-1:0]  r_granted;
    logic                r_live;
    logic [UCNT_W-1:0]   r_used;

    logic                w_accept, w_fire, w_we, w_cfg_wr;
    logic [2:0]          w_reg_idx;
    logic [PA_W-1:0]     w_raddr, w_pidx;
    logic [WORD_W-1:0]   w_rdata, w_word, w_wdata;
    logic [MAX_LAYERS-1:0] w_map, w_mask, w_free, w_new_map;
    logic [CNT_W-1:0]    w_cnt, w_new_cnt, w_n;
    logic                w_ok, w_layer_ok;
    logic [LIDX_W-1:0]   w_first, w_lidx;
    logic [STAT_W-1:0]   w_status;
    logic [GRANT_W-1:0]  w_granted;
    logic                w_live;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_reg_idx = paddr[4:2];

    always_comb begin
        prdata = '0;
        if (w_reg_idx == REG_POOL_TOTAL) begin
            prdata = APB_DW'(r_total);
        end else begin
            for (int p = 0; p < NUM_POOLS; p++) begin
                if (p < REG_POOLS && w_reg_idx == 3'(p + 1)) begin
                    prdata = APB_DW'(r_layers[p]);
                end
            end
        end
    end

    // ---------------- handshake ----------------
    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_fire     = (r_state == S_EXEC) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (w_fire) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------- bitmap memory ----------------
    assign w_raddr = (r_state == S_IDLE) ? PA_W'(i_pool_sel) : PA_W'(r_pool);
    assign w_pidx  = PA_W'(r_pool);

    mpla_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_POOLS)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_pidx),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // ---------------- modify step ----------------
    always_comb begin
        w_n = '0;
        for (int p = 0; p < NUM_POOLS; p++) begin
            if (r_pool == POOL_W'(p)) w_n = eff_layers(r_layers[p]);
        end
        w_ok = (r_pool < r_total) && (r_pool < POOL_W'(NUM_POOLS)) && (w_n != '0);

        // a word never written since reset or a size change reads as empty
        w_word = r_vld[w_pidx] ? w_rdata : '0;
        w_map  = w_word[MAX_LAYERS-1:0];
        w_cnt  = w_word[WORD_W-1:MAX_LAYERS];

        for (int i = 0; i < MAX_LAYERS; i++) begin
            w_mask[i] = (CNT_W'(i) < w_n);
        end
        w_free = ~w_map & w_mask;

        // lowest free layer
        w_first = '0;
        for (int i = MAX_LAYERS - 1; i >= 0; i--) begin
            if (w_free[i]) w_first = LIDX_W'(i);
        end

        w_layer_ok = (r_layer < LSEL_W'(w_n));
        w_lidx     = LIDX_W'(r_layer);

        w_new_map = w_map;
        w_new_cnt = w_cnt;
        w_status  = ST_OK;
        w_granted = '0;
        w_live    = 1'b0;

        if (!w_ok) begin
            w_status = ST_BAD_POOL;
        end else begin
            case (r_act)
                ACT_ALLOC: begin
                    if (w_free == '0) begin
                        w_status = ST_FULL;
                    end else begin
                        w_new_map[w_first] = 1'b1;
                        w_new_cnt = CNT_W'(w_cnt + 1'b1);
                        w_granted = GRANT_W'(w_first);
                    end
                end
                ACT_RELEASE: begin
                    if (!w_layer_ok) begin
                        w_status = ST_BAD_LAYER;
                    end else if (w_map[w_lidx]) begin
                        w_new_map[w_lidx] = 1'b0;
                        w_new_cnt = CNT_W'(w_cnt - 1'b1);
                    end
                end
                ACT_CHECK: begin
                    if (!w_layer_ok) begin
                        w_status = ST_BAD_LAYER;
                    end else begin
                        w_live = w_map[w_lidx];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign w_we    = w_fire && w_ok;
    assign w_wdata = {w_new_cnt, w_new_map};

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_vld       <= '0;
            r_total     <= '0;
            for (int p = 0; p < NUM_POOLS; p++) r_layers[p] <= '0;
        end else begin
            r_state <= n_state;
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_we) r_vld[w_pidx] <= 1'b1;
            if (w_cfg_wr) begin
                if (w_reg_idx == REG_POOL_TOTAL) begin
                    r_total <= pwdata[TOT_W-1:0];
                end
                for (int p = 0; p < NUM_POOLS; p++) begin
                    if (p < REG_POOLS && w_reg_idx == 3'(p + 1)) begin
                        r_layers[p] <= pwdata[LRAW_W-1:0];
                        r_vld[p]    <= 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_act   <= i_action;
            r_pool  <= i_pool_sel;
            r_layer <= i_layer_sel;
        end
        if (w_fire) begin
            r_status  <= w_status;
            r_granted <= w_granted;
            r_live    <= w_live;
            r_used    <= w_ok ? UCNT_W'(w_new_cnt) : '0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_granted_layer = r_granted;
    assign o_is_live       = r_live;
    assign o_used_count    = r_used;

    // ---------------- assertions ----------------
    a_we_only_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == S_EXEC))
        else $error("bitmap written outside the modify step");

    a_fire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> o_out_valid)
        else $error("finished item produced no result");

    a_used_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_used_count <= UCNT_W'(MAX_LAYERS)))
        else $error("used count above pool size");

    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> (o_granted_layer == '0 && !o_is_live))
        else $error("error result carries a grant or live flag");

    a_bad_pool_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_BAD_POOL) |-> (o_used_count == '0))
        else $error("bad pool result carries a used count");

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for multi_pool_layer_allocator_top: first-fit layer allocation.
// Depends on mpla_pkg and the allocator RTL. Pools are set up over APB between
// phases, with an in-bench model of the bitmaps predicting every result item.
module testbench;
    import mpla_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [POOL_W-1:0] pool;
        logic [LSEL_W-1:0] layer;
    } alloc_req_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [GRANT_W-1:0] granted;
        logic               live;
        logic [UCNT_W-1:0]  used;
    } alloc_res_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic [ACT_W-1:0]   i_action = '0;
    logic [POOL_W-1:0]  i_pool_sel = '0;
    logic [LSEL_W-1:0]  i_layer_sel = '0;
    logic               i_out_stall = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [APB_AW-1:0]  paddr = '0;
    logic [APB_DW-1:0]  pwdata = '0;

    wire                o_in_stall;
    wire                o_out_valid;
    wire [STAT_W-1:0]   o_status;
    wire [GRANT_W-1:0]  o_granted_layer;
    wire                o_is_live;
    wire [UCNT_W-1:0]   o_used_count;
    wire [APB_DW-1:0]   prdata;
    wire                pready;

    multi_pool_layer_allocator_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_pool_sel      (i_pool_sel),
        .i_layer_sel     (i_layer_sel),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_granted_layer (o_granted_layer),
        .o_is_live       (o_is_live),
        .o_used_count    (o_used_count),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // model of the allocator registers and bitmaps
    logic [TOT_W-1:0]      total_reg = '0;
    logic [LRAW_W-1:0]     layer_reg [NUM_POOLS];
    logic [MAX_LAYERS-1:0] busy_map [NUM_POOLS];

    alloc_req_t request_queue[$];
    alloc_res_t expected_results[$];
    alloc_req_t cur_req = '0;
    bit         cur_busy = 1'b0;
    bit         item_taken = 1'b0;
    bit         calm = 1'b0;
    int         errors = 0;
    int         quiet_cycles = 0;

    initial begin
        for (int p = 0; p < NUM_POOLS; p++) begin
            layer_reg[p] = '0;
            busy_map[p] = '0;
        end
    end

    function automatic void add_request(input alloc_req_t r);
        request_queue = {request_queue, r};
    endfunction

    function automatic void add_expected(input alloc_res_t e);
        expected_results = {expected_results, e};
    endfunction

    function automatic int pool_size(input int p);
        return (layer_reg[p] > MAX_LAYERS) ? MAX_LAYERS : int'(layer_reg[p]);
    endfunction

    function automatic alloc_res_t serve_request(input alloc_req_t r);
        alloc_res_t            o;
        logic [MAX_LAYERS-1:0] span;
        logic [MAX_LAYERS-1:0] vacant;
        int                    lim;
        int                    n;
        o = '0;
        lim = (total_reg > NUM_POOLS) ? NUM_POOLS : int'(total_reg);
        n = (int'(r.pool) < lim) ? pool_size(r.pool) : 0;
        if (n == 0) begin
            o.status = ST_BAD_POOL;
            return o;
        end
        span = '0;
        for (int i = 0; i < n; i++) span[i] = 1'b1;
        case (r.action)
            ACT_ALLOC: begin
                vacant = ~busy_map[r.pool] & span;
                if (vacant == '0) begin
                    o.status = ST_FULL;
                end else begin
                    for (int i = n - 1; i >= 0; i--) begin
                        if (vacant[i]) o.granted = GRANT_W'(i);
                    end
                    busy_map[r.pool][o.granted] = 1'b1;
                end
            end
            ACT_RELEASE: begin
                if (r.layer >= n) o.status = ST_BAD_LAYER;
                else busy_map[r.pool][r.layer] = 1'b0;
            end
            ACT_CHECK: begin
                if (r.layer >= n) o.status = ST_BAD_LAYER;
                else o.live = busy_map[r.pool][r.layer];
            end
            default: ;
        endcase
        o.used = UCNT_W'($countones(busy_map[r.pool] & span));
        return o;
    endfunction

    task automatic note_mismatch(input string field, input int want_v, input int got_v);
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want_v, got_v);
        errors++;
    endtask

    // request driver: a new item only once the previous one was taken
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (item_taken) begin
                cur_busy = 1'b0;
                item_taken = 1'b0;
            end
            if (!cur_busy && request_queue.size() != 0 &&
                (calm || $urandom_range(0, 99) >= 35)) begin
                cur_req = request_queue.pop_front();
                cur_busy = 1'b1;
            end
            i_in_valid <= cur_busy;
            i_action <= cur_req.action;
            i_pool_sel <= cur_req.pool;
            i_layer_sel <= cur_req.layer;
            i_out_stall <= !calm && ($urandom_range(0, 99) < 35);
        end
    end

    // monitor: predict on accept, compare on each result item
    always @(posedge i_clk) begin
        alloc_res_t want;
        alloc_res_t got;
        if (i_rst_n) begin
            quiet_cycles++;
            if (i_in_valid && !o_in_stall) begin
                add_expected(serve_request({i_action, i_pool_sel, i_layer_sel}));
                item_taken = 1'b1;
                quiet_cycles = 0;
            end
            if (o_out_valid && !i_out_stall) begin
                quiet_cycles = 0;
                got = {o_status, o_granted_layer, o_is_live, o_used_count};
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result item: expected none, actual %h", $time, got);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status)
                        note_mismatch("status", want.status, got.status);
                    if (got.granted !== want.granted)
                        note_mismatch("granted_layer", want.granted, got.granted);
                    if (got.live !== want.live)
                        note_mismatch("is_live", want.live, got.live);
                    if (got.used !== want.used)
                        note_mismatch("used_count", want.used, got.used);
                end
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic write_reg(input int idx, input int value);
        logic [APB_DW-1:0] word;
        int                p;
        word = ($urandom << 6) | (value & 63);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_AW'(idx * 4);
        pwdata <= word;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        p = idx - int'(REG_LAYERS0);
        if (idx == int'(REG_POOL_TOTAL)) begin
            total_reg = word[TOT_W-1:0];
        end else if (p >= 0 && p < REG_POOLS && p < NUM_POOLS) begin
            layer_reg[p] = word[LRAW_W-1:0];
            busy_map[p] = '0;
        end
    endtask

    task automatic set_pools(input int total, input int l0, input int l1,
                             input int l2, input int l3);
        write_reg(REG_POOL_TOTAL, total);
        write_reg(REG_LAYERS0 + 0, l0);
        write_reg(REG_LAYERS0 + 1, l1);
        write_reg(REG_LAYERS0 + 2, l2);
        write_reg(REG_LAYERS0 + 3, l3);
    endtask

    // hold off the sender until every result item is back
    task automatic drain();
        while (request_queue.size() != 0 || cur_busy || expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic queue_item(input logic [ACT_W-1:0] a, input int pl, input int ly);
        alloc_req_t r;
        r.action = a;
        r.pool = POOL_W'(pl);
        r.layer = LSEL_W'(ly);
        add_request(r);
    endtask

    // occasional fill/drain bursts on one pool, mostly single mixed requests
    task automatic add_traffic(input int count);
        alloc_req_t r;
        int         added;
        int         kind;
        int         p;
        int         n;
        int         roll;
        added = 0;
        while (added < count) begin
            kind = $urandom_range(0, 39);
            p = $urandom_range(0, NUM_POOLS - 1);
            n = pool_size(p);
            if (kind == 0) begin
                repeat (n + 1) queue_item(ACT_ALLOC, p, $urandom_range(0, 63));
                added += n + 1;
            end else if (kind == 1) begin
                for (int i = n - 1; i >= 0; i--) queue_item(ACT_RELEASE, p, i);
                added += n;
            end else begin
                roll = $urandom_range(0, 99);
                r.action = (roll < 5) ? ACT_SPARE : (roll < 50) ? ACT_ALLOC :
                           (roll < 75) ? ACT_RELEASE : ACT_CHECK;
                r.pool = ($urandom_range(0, 99) < 15) ? POOL_W'($urandom_range(0, 7))
                                                      : POOL_W'(p);
                r.layer = ($urandom_range(0, 99) < 15 || n == 0) ? LSEL_W'($urandom)
                                                                 : LSEL_W'($urandom_range(0, n - 1));
                add_request(r);
                added++;
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // nothing configured: every pool is absent
        queue_item(ACT_ALLOC, 0, 0);
        queue_item(ACT_CHECK, 0, 0);
        queue_item(ACT_RELEASE, 3, 5);
        queue_item(ACT_SPARE, 0, 0);
        drain();

        // count 63 saturates to 32
        set_pools(4, 32, 1, 5, 63);
        queue_item(ACT_ALLOC, 0, 17);
        queue_item(ACT_ALLOC, 1, 0);
        queue_item(ACT_ALLOC, 1, 0);     // single-layer pool now full
        queue_item(ACT_CHECK, 1, 0);
        queue_item(ACT_CHECK, 1, 1);
        queue_item(ACT_RELEASE, 1, 0);
        queue_item(ACT_RELEASE, 1, 0);   // already free
        queue_item(ACT_CHECK, 1, 0);
        queue_item(ACT_CHECK, 0, 63);
        queue_item(ACT_RELEASE, 0, 32);  // layer equal to count
        queue_item(ACT_ALLOC, 4, 0);
        queue_item(ACT_ALLOC, 7, 0);
        queue_item(ACT_CHECK, 7, 63);
        queue_item(ACT_SPARE, 0, 63);
        queue_item(ACT_SPARE, 5, 0);
        queue_item(ACT_ALLOC, 3, 0);
        queue_item(ACT_CHECK, 3, 31);
        queue_item(ACT_RELEASE, 3, 31);
        repeat (6) queue_item(ACT_ALLOC, 2, 0);
        queue_item(ACT_RELEASE, 2, 2);
        queue_item(ACT_ALLOC, 2, 0);     // reuses the lowest hole
        add_traffic(330);
        drain();

        // total above the pool count, an absent pool, no idling on either side
        calm = 1'b1;
        set_pools(7, 0, 31, 2, 33);
        add_traffic(300);
        drain();
        calm = 1'b0;

        // shrink, then grow back: bitmaps of hidden pools survive
        write_reg(REG_POOL_TOTAL, 2);
        add_traffic(200);
        drain();
        write_reg(REG_POOL_TOTAL, 4);
        add_traffic(150);
        drain();

        set_pools(3, 32, 32, 17, 0);
        write_reg(NUM_REGS, 5);          // no such register
        add_traffic(300);
        drain();

        set_pools(1, 3, 63, 63, 63);
        add_traffic(140);
        drain();

        write_reg(REG_POOL_TOTAL, 0);
        add_traffic(20);
        drain();

        repeat (10) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            $display("%0t: %0d result items never arrived", $time, expected_results.size());
            errors++;
        end
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
